[rtl/tftp_wr_pkg.sv]
// ----------------------------------------------------------------------------
// tftp_wr_pkg
// Shared types and constants of the TFTP write receive engine.
// ----------------------------------------------------------------------------
package tftp_wr_pkg;

	localparam int unsigned BUFFER_BYTES_DEF = 8388608;

	localparam logic [15:0] LOCAL_PORT_RST     = 16'd69;
	localparam logic [15:0] FULL_BLOCK_LEN_RST = 16'd512;

	// configuration register indexes
	localparam logic CFG_LOCAL_PORT     = 1'b0;
	localparam logic CFG_FULL_BLOCK_LEN = 1'b1;

	// TFTP opcodes on the wire
	localparam logic [15:0] OP_RRQ  = 16'd1;
	localparam logic [15:0] OP_WRQ  = 16'd2;
	localparam logic [15:0] OP_DATA = 16'd3;
	localparam logic [15:0] OP_ERR  = 16'd5;

	// reply opcodes in the result
	localparam logic [2:0] ROPC_NONE = 3'd0;
	localparam logic [2:0] ROPC_DATA = 3'd3;
	localparam logic [2:0] ROPC_ACK  = 3'd4;

	typedef enum logic [2:0] {
		ACT_DROP    = 3'd0,
		ACT_REPLY   = 3'd1,
		ACT_STORED  = 3'd2,
		ACT_DUP     = 3'd3,
		ACT_RESTART = 3'd4,
		ACT_RESEND  = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		OPK_RRQ   = 3'd0,
		OPK_WRQ   = 3'd1,
		OPK_DATA  = 3'd2,
		OPK_ERR   = 3'd3,
		OPK_OTHER = 3'd4
	} opkind_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        timer;      // retransmit timer tick
		logic        port_ok;    // right destination port and at least the opcode
		logic        len_ok;     // long enough for a DATA header
		logic        short_blk;  // payload below a full block
		opkind_t     kind;
		logic [15:0] src_port;
		logic [15:0] blk;
		logic [15:0] len;        // payload bytes after the DATA header
	} cls_t;

	typedef struct packed {
		action_t     action;
		logic [2:0]  reply_opcode;
		logic [15:0] reply_block;
		logic [15:0] reply_port;
		logic [23:0] store_offset;
		logic [15:0] store_len;
		logic        done_res;
		logic        overflow;
	} res_t;

endpackage

[rtl/tftp_write_receive_engine.sv]
// ----------------------------------------------------------------------------
// tftp_write_receive_engine
// TFTP server write receive engine: one packet header or timer tick in,
// one result out.
//
// s_* channel: one item per TFTP packet header (tuser = timer tick flag).
// m_* channel: one result per input item, in order (tuser = action,
// tlast = transfer finished on a short block).
// cfg_*: register writes, always ready; index 0 local port, 1 full block
// length. Write only while no item is in flight.
// From input accept to result valid an item passes the front decode
// register, which loads at the accepting edge, then the two-entry queue
// and then the result register of the state machine.
// Throughput is one item per cycle while m_tready is high; the state
// update of the back end is computed combinationally from each item.
// Reset clears the transfer state (waiting for a request, no partner, count
// zero) and loads local port 69 and full block length 512.
// When m_tready is low the result register holds, the queue fills, and
// s_tready drops once the front decode register is also occupied.
// ----------------------------------------------------------------------------
module tftp_write_receive_engine import tftp_wr_pkg::*; #(
	parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// dst_port, src_port, udp_len, opcode, block_word
	input  logic [79:0] s_tdata,
	// func
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// reply_opcode, reply_block, reply_port, store_offset, store_len, overflow
	output logic [79:0] m_tdata,
	// action
	output logic [2:0]  m_tuser,
	// done_res
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] local_port_q;
	logic [15:0] full_block_len_q;
	logic        f_valid;
	logic        f_ready;
	cls_t        f_cls;
	logic        q_valid;
	logic        q_ready;
	cls_t        q_cls;
	res_t        res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_port_q     <= LOCAL_PORT_RST;
			full_block_len_q <= FULL_BLOCK_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOCAL_PORT:     local_port_q     <= cfg_data;
				CFG_FULL_BLOCK_LEN: full_block_len_q <= cfg_data;
				default:            local_port_q     <= local_port_q;
			endcase
		end
	end

	tftp_wr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.local_port     (local_port_q),
		.full_block_len (full_block_len_q),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_func        (s_tuser[0]),
		.in_dst_port    (s_tdata[15:0]),
		.in_src_port    (s_tdata[31:16]),
		.in_udp_len     (s_tdata[47:32]),
		.in_opcode      (s_tdata[63:48]),
		.in_block_word  (s_tdata[79:64]),
		.cls_valid      (f_valid),
		.cls_ready      (f_ready),
		.cls            (f_cls)
	);

	tftp_wr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_cls),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_cls)
	);

	tftp_wr_back #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (q_valid),
		.cls_ready (q_ready),
		.cls       (q_cls),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tuser = res.action;
	assign m_tlast = res.done_res;
	assign m_tdata = {4'b0000, res.overflow, res.store_len, res.store_offset,
		res.reply_port, res.reply_block, res.reply_opcode};

endmodule

[rtl/tftp_wr_front.sv]
// ----------------------------------------------------------------------------
// tftp_wr_front
// Accepts packet headers, decodes opcode and length checks into a register.
// ----------------------------------------------------------------------------
module tftp_wr_front import tftp_wr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] local_port,
	input  logic [15:0] full_block_len,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_func,
	input  logic [15:0] in_dst_port,
	input  logic [15:0] in_src_port,
	input  logic [15:0] in_udp_len,
	input  logic [15:0] in_opcode,
	input  logic [15:0] in_block_word,
	output logic        cls_valid,
	input  logic        cls_ready,
	output cls_t        cls
);

	logic    valid_s1;
	cls_t    cls_s1;
	cls_t    cls_d;
	opkind_t kind;
	logic [15:0] len;

	always_comb begin
		unique case (in_opcode)
			OP_RRQ:  kind = OPK_RRQ;
			OP_WRQ:  kind = OPK_WRQ;
			OP_DATA: kind = OPK_DATA;
			OP_ERR:  kind = OPK_ERR;
			default: kind = OPK_OTHER;
		endcase
	end

	assign len = in_udp_len - 16'd4;

	always_comb begin
		cls_d.timer     = in_func;
		cls_d.port_ok   = (in_dst_port == local_port) && (in_udp_len >= 16'd2);
		cls_d.len_ok    = in_udp_len >= 16'd4;
		cls_d.short_blk = len < full_block_len;
		cls_d.kind      = kind;
		cls_d.src_port  = in_src_port;
		cls_d.blk       = in_block_word;
		cls_d.len       = len;
	end

	assign in_ready  = !valid_s1 || cls_ready;
	assign cls_valid = valid_s1;
	assign cls       = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (cls_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

[rtl/tftp_wr_fifo.sv]
// ----------------------------------------------------------------------------
// tftp_wr_fifo
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module tftp_wr_fifo import tftp_wr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cls_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cls_t rd_data
);

	cls_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[rtl/tftp_wr_back.sv]
// ----------------------------------------------------------------------------
// tftp_wr_back
// Transfer state machine: applies each classified item and registers the result.
// ----------------------------------------------------------------------------
module tftp_wr_back import tftp_wr_pkg::*; #(
	parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cls_valid,
	output logic cls_ready,
	input  cls_t cls,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
	localparam logic [CNT_W-1:0] BUF_LIMIT = CNT_W'(BUFFER_BYTES);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_WREQ = 4'b0010,
		PH_RECV = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	phase_t           ph_q,      ph_d;
	logic [15:0]      partner_q, partner_d;
	logic [15:0]      cur_q,     cur_d;
	logic [15:0]      prev_q,    prev_d;
	logic [CNT_W-1:0] bc_q,      bc_d;
	logic             armed_q,   armed_d;
	logic             valid_q;
	res_t             res_q;
	res_t             res_d;
	logic             pop;
	logic             accept_pkt;
	logic [15:0]      prev_eff;
	logic [CNT_W-1:0] room;
	logic             ovf;

	assign cls_ready = !valid_q || res_ready;
	assign pop       = cls_valid && cls_ready;
	assign res_valid = valid_q;
	assign res       = res_q;

	assign accept_pkt = cls.port_ok && (ph_q == PH_IDLE || cls.src_port == partner_q);
	assign prev_eff   = (ph_q == PH_WREQ) ? 16'd0 : prev_q;
	assign room       = BUF_LIMIT - bc_q;
	assign ovf        = CNT_W'(cls.len) > room;

	always_comb begin
		ph_d      = ph_q;
		partner_d = partner_q;
		cur_d     = cur_q;
		prev_d    = prev_q;
		bc_d      = bc_q;
		armed_d   = armed_q;

		res_d.action       = ACT_DROP;
		res_d.reply_opcode = ROPC_NONE;
		res_d.reply_block  = 16'd0;
		res_d.store_offset = 24'd0;
		res_d.store_len    = 16'd0;
		res_d.done_res     = 1'b0;
		res_d.overflow     = 1'b0;

		if (cls.timer) begin
			if (armed_q && ph_q != PH_DONE) begin
				res_d.action       = ACT_RESEND;
				res_d.reply_opcode = (ph_q == PH_IDLE) ? ROPC_DATA : ROPC_ACK;
				res_d.reply_block  = cur_q;
			end
		end else if (accept_pkt) begin
			unique case (cls.kind)
				OPK_RRQ: begin
					partner_d          = cls.src_port;
					cur_d              = 16'd1;
					ph_d               = PH_IDLE;
					res_d.action       = ACT_REPLY;
					res_d.reply_opcode = ROPC_DATA;
					res_d.reply_block  = 16'd1;
				end
				OPK_WRQ: begin
					partner_d          = cls.src_port;
					cur_d              = 16'd0;
					ph_d               = PH_WREQ;
					bc_d               = '0;
					res_d.action       = ACT_REPLY;
					res_d.reply_opcode = ROPC_ACK;
				end
				OPK_DATA: begin
					if (cls.len_ok && (ph_q == PH_WREQ || ph_q == PH_RECV)) begin
						if (ph_q == PH_WREQ && cls.blk != 16'd1) begin
							// first block must be 1, otherwise start over
							ph_d         = PH_IDLE;
							partner_d    = 16'd0;
							cur_d        = 16'd0;
							prev_d       = 16'd0;
							bc_d         = '0;
							armed_d      = 1'b0;
							res_d.action = ACT_RESTART;
						end else begin
							cur_d  = cls.blk;
							ph_d   = PH_RECV;
							prev_d = prev_eff;
							if (cls.blk == prev_eff) begin
								res_d.action = ACT_DUP;
							end else begin
								prev_d             = cls.blk;
								armed_d            = 1'b1;
								res_d.action       = ACT_STORED;
								res_d.reply_opcode = ROPC_ACK;
								res_d.reply_block  = cls.blk;
								if (ovf) begin
									res_d.overflow = 1'b1;
									bc_d           = BUF_LIMIT;
								end else begin
									res_d.store_offset = 24'(bc_q);
									res_d.store_len    = cls.len;
									bc_d               = CNT_W'(bc_q + CNT_W'(cls.len));
								end
								if (cls.short_blk) begin
									ph_d           = PH_DONE;
									res_d.done_res = 1'b1;
								end
							end
						end
					end
				end
				OPK_ERR: begin
					ph_d         = PH_IDLE;
					partner_d    = 16'd0;
					cur_d        = 16'd0;
					prev_d       = 16'd0;
					bc_d         = '0;
					armed_d      = 1'b0;
					res_d.action = ACT_RESTART;
				end
				default: begin
				end
			endcase
		end

		res_d.reply_port = (res_d.reply_opcode != ROPC_NONE) ? partner_d : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= PH_IDLE;
			partner_q <= 16'd0;
			cur_q     <= 16'd0;
			prev_q    <= 16'd0;
			bc_q      <= '0;
			armed_q   <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				ph_q      <= ph_d;
				partner_q <= partner_d;
				cur_q     <= cur_d;
				prev_q    <= prev_d;
				bc_q      <= bc_d;
				armed_q   <= armed_d;
				valid_q   <= 1'b1;
			end else if (res_ready) begin
				valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= BUF_LIMIT)
		else $error("byte count above buffer size");

	a_ovf_nostore: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.overflow |-> res_q.store_len == 16'd0 && res_q.action == ACT_STORED)
		else $error("overflow result carries a store");

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pop && res_d.done_res |=> ph_q == PH_DONE && valid_q && res_q.action == ACT_STORED)
		else $error("short block did not finish transfer");

	a_restart_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pop && res_d.action == ACT_RESTART |=> bc_q == '0 && !armed_q && ph_q == PH_IDLE)
		else $error("restart left state behind");

endmodule
